FILE: rtl/plist_pkg.sv
// Shared types, codes and size constants for the positional list engine.
`timescale 1ns / 1ps

package plist_pkg;

    // Default number of slots in the store
    localparam int CAPACITY_DEF = 32;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    // Command beat
    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } plist_request_t;

    // Result beat
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        element_count;
        logic signed [VALUE_W-1:0] element_value;
        logic                      element_valid;
        logic                      last;
    } plist_result_t;

endpackage

FILE: rtl/plist_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/positional_list_engine_core.sv
// Top level: sequencer, link walker and slot stores of the positional list engine.
//
//  Channel   Handshake                 Payload            Direction
//  command   start, busy               request            in  (taken when start & !busy)
//  result    result_valid (strobe)     result             out (each beat valid for a single cycle)
//
// A command is taken on a clock edge with start high and busy low; busy then stays high
// until the edge that registers the final result beat. Errors, insert into an empty list,
// empty dump and unused codes end in the decode state. Insert at the front starts from the
// tail; insert at p >= 2 (back is count + 1) walks from the head to the predecessor; both
// then link the new slot in. Delete at p (front is 1, back is count) walks from the head to
// the target. Dump walks from the head, one beat per element. The link walker follows one
// next pointer per cycle through the registered read port of the link store.
// Reset clears head, tail, count and the free-stack pointers; the slot stores need no
// clearing. Result beats cannot be held off by the receiver.
`timescale 1ns / 1ps

module positional_list_engine_core #(
    parameter int CAPACITY = plist_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  plist_pkg::plist_request_t request,
    output logic                     result_valid,
    output plist_pkg::plist_result_t result
);

    import plist_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_RW = $clog2(CAPACITY + 2);
    localparam int CMP_W  = (POS_W > CMP_RW) ? POS_W : CMP_RW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_LINK,
        ST_DUMP
    } state_t;

    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      steps_reg, steps_next;
    logic [IDX_W-1:0]      pred_reg, pred_next;
    logic [IDX_W-1:0]      succ_reg, succ_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      top_reg, top_next;
    logic [CNT_W-1:0]      lwm_reg, lwm_next;
    plist_result_t         result_reg, result_next;
    logic                  result_valid_reg, result_valid_next;

    // Store ports
    logic [IDX_W-1:0]      rd_addr;
    logic                  val_we, nxt_we, prv_we, free_we;
    logic [IDX_W-1:0]      val_waddr, nxt_waddr, prv_waddr, free_waddr;
    logic [VALUE_W-1:0]    val_wdata, val_rdata;
    logic [IDX_W-1:0]      nxt_wdata, nxt_rdata;
    logic [IDX_W-1:0]      prv_wdata, prv_rdata;
    logic [IDX_W-1:0]      free_wdata, free_rdata, free_raddr;

    // Decode helpers
    logic                  is_insert, is_delete;
    logic [CMP_W-1:0]      cnt_ext, pos_eff;
    logic                  ins_range_bad, del_range_bad, list_full, list_empty;
    logic [CNT_W-1:0]      top_m1;
    logic                  fresh;
    logic [IDX_W-1:0]      slot_new;

    // Slot stores and free-slot stack
    plist_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rdata)
    );

    plist_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (rd_addr),
        .rdata (nxt_rdata)
    );

    plist_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (rd_addr),
        .rdata (prv_rdata)
    );

    plist_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
        .clk   (clk),
        .we    (free_we),
        .waddr (free_waddr),
        .wdata (free_wdata),
        .raddr (free_raddr),
        .rdata (free_rdata)
    );

    // Operation class and effective position
    assign is_insert = op_reg inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_AT};
    assign is_delete = op_reg inside {OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT};
    assign cnt_ext   = CMP_W'(count_reg);

    always_comb
    begin
        case (op_reg)
            OP_INS_FRONT, OP_DEL_FRONT: pos_eff = CMP_W'(1);
            OP_INS_BACK:                pos_eff = cnt_ext + CMP_W'(1);
            OP_DEL_BACK:                pos_eff = cnt_ext;
            default:                    pos_eff = CMP_W'(pos_reg);
        endcase
    end

    assign ins_range_bad = (pos_eff == '0) || (pos_eff > cnt_ext + CMP_W'(1));
    assign del_range_bad = (pos_eff == '0) || (pos_eff > cnt_ext);
    assign list_full     = (count_reg == CNT_W'(CAPACITY));
    assign list_empty    = (count_reg == '0);

    // Free stack pop: entries below the low-water mark were never pushed, so their index is used as the slot
    assign top_m1     = top_reg - CNT_W'(1);
    assign fresh      = (top_m1 < lwm_reg);
    assign free_raddr = IDX_W'(top_m1);
    assign slot_new   = fresh ? IDX_W'(top_m1) : free_rdata;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        value_next        = value_reg;
        pos_next          = pos_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        cur_next          = cur_reg;
        steps_next        = steps_reg;
        pred_next         = pred_reg;
        succ_next         = succ_reg;
        count_next        = count_reg;
        top_next          = top_reg;
        lwm_next          = lwm_reg;
        result_next       = '0;
        result_valid_next = 1'b0;

        rd_addr    = cur_reg;
        val_we     = 1'b0;
        val_waddr  = slot_new;
        val_wdata  = value_reg;
        nxt_we     = 1'b0;
        nxt_waddr  = slot_new;
        nxt_wdata  = slot_new;
        prv_we     = 1'b0;
        prv_waddr  = slot_new;
        prv_wdata  = slot_new;
        free_we    = 1'b0;
        free_waddr = IDX_W'(top_reg);
        free_wdata = cur_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = request.operation;
                    value_next = request.value;
                    pos_next   = request.position;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                if (is_insert)
                begin
                    if (ins_range_bad)
                    begin
                        result_next.status = STATUS_RANGE;
                        result_next.last   = 1'b1;
                        result_valid_next  = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else if (list_full)
                    begin
                        result_next.status = STATUS_FULL;
                        result_next.last   = 1'b1;
                        result_valid_next  = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else if (list_empty)
                    begin
                        // First element links to itself
                        val_we     = 1'b1;
                        nxt_we     = 1'b1;
                        prv_we     = 1'b1;
                        head_next  = slot_new;
                        tail_next  = slot_new;
                        count_next = count_reg + CNT_W'(1);
                        top_next   = top_m1;
                        if (fresh)
                        begin
                            lwm_next = top_m1;
                        end
                        result_next.status = STATUS_OK;
                        result_next.last   = 1'b1;
                        result_valid_next  = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        // Find the predecessor: tail for the front, else walk from head
                        if (pos_eff == CMP_W'(1))
                        begin
                            rd_addr    = tail_reg;
                            cur_next   = tail_reg;
                            steps_next = '0;
                        end
                        else
                        begin
                            rd_addr    = head_reg;
                            cur_next   = head_reg;
                            steps_next = IDX_W'(pos_eff - CMP_W'(2));
                        end
                        state_next = ST_WALK;
                    end
                end
                else if (is_delete)
                begin
                    if (list_empty)
                    begin
                        result_next.status = STATUS_EMPTY;
                        result_next.last   = 1'b1;
                        result_valid_next  = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else if (del_range_bad)
                    begin
                        result_next.status = STATUS_RANGE;
                        result_next.last   = 1'b1;
                        result_valid_next  = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        rd_addr    = head_reg;
                        cur_next   = head_reg;
                        steps_next = IDX_W'(pos_eff - CMP_W'(1));
                        state_next = ST_WALK;
                    end
                end
                else if (op_reg == OP_DUMP && !list_empty)
                begin
                    rd_addr    = head_reg;
                    cur_next   = head_reg;
                    steps_next = IDX_W'(count_reg - CNT_W'(1));
                    state_next = ST_DUMP;
                end
                else
                begin
                    // Empty dump or unused code: single plain beat
                    result_next.status = STATUS_OK;
                    result_next.last   = 1'b1;
                    result_valid_next  = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_WALK:
            begin
                if (steps_reg != '0)
                begin
                    // One link per cycle
                    rd_addr    = nxt_rdata;
                    cur_next   = nxt_rdata;
                    steps_next = steps_reg - IDX_W'(1);
                end
                else if (is_insert)
                begin
                    // New slot takes value and links to pred and succ
                    pred_next = cur_reg;
                    succ_next = nxt_rdata;
                    val_we    = 1'b1;
                    nxt_we    = 1'b1;
                    nxt_wdata = nxt_rdata;
                    prv_we    = 1'b1;
                    prv_wdata = cur_reg;
                    state_next = ST_LINK;
                end
                else
                begin
                    // Unlink the target and return its slot
                    if (count_reg == CNT_W'(1))
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else
                    begin
                        nxt_we    = 1'b1;
                        nxt_waddr = prv_rdata;
                        nxt_wdata = nxt_rdata;
                        prv_we    = 1'b1;
                        prv_waddr = nxt_rdata;
                        prv_wdata = prv_rdata;
                        if (cur_reg == head_reg)
                        begin
                            head_next = nxt_rdata;
                        end
                        if (cur_reg == tail_reg)
                        begin
                            tail_next = prv_rdata;
                        end
                    end
                    free_we    = 1'b1;
                    top_next   = top_reg + CNT_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    result_next.status = STATUS_OK;
                    result_next.last   = 1'b1;
                    result_valid_next  = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_LINK:
            begin
                // Neighbors point at the new slot
                nxt_we    = 1'b1;
                nxt_waddr = pred_reg;
                nxt_wdata = slot_new;
                prv_we    = 1'b1;
                prv_waddr = succ_reg;
                prv_wdata = slot_new;
                if (pos_eff == CMP_W'(1))
                begin
                    head_next = slot_new;
                end
                if (pos_eff == cnt_ext + CMP_W'(1))
                begin
                    tail_next = slot_new;
                end
                count_next = count_reg + CNT_W'(1);
                top_next   = top_m1;
                if (fresh)
                begin
                    lwm_next = top_m1;
                end
                result_next.status = STATUS_OK;
                result_next.last   = 1'b1;
                result_valid_next  = 1'b1;
                state_next         = ST_IDLE;
            end

            ST_DUMP:
            begin
                // One element beat per cycle
                result_next.status        = STATUS_OK;
                result_next.element_value = val_rdata;
                result_next.element_valid = 1'b1;
                result_valid_next         = 1'b1;
                if (steps_reg == '0)
                begin
                    result_next.last = 1'b1;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    rd_addr    = nxt_rdata;
                    cur_next   = nxt_rdata;
                    steps_next = steps_reg - IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        result_next.element_count = COUNT_W'(count_next);
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= '0;
            value_reg        <= '0;
            pos_reg          <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            cur_reg          <= '0;
            steps_reg        <= '0;
            pred_reg         <= '0;
            succ_reg         <= '0;
            count_reg        <= '0;
            top_reg          <= CNT_W'(CAPACITY);
            lwm_reg          <= CNT_W'(CAPACITY);
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            value_reg        <= value_next;
            pos_reg          <= pos_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            cur_reg          <= cur_next;
            steps_reg        <= steps_next;
            pred_reg         <= pred_next;
            succ_reg         <= succ_next;
            count_reg        <= count_next;
            top_reg          <= top_next;
            lwm_reg          <= lwm_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/plist_checker.sv
// Port-level assertions for the positional list engine, bound to the top level.
`timescale 1ns / 1ps

module plist_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     result_valid,
    input plist_pkg::plist_result_t result
);

    import plist_pkg::*;

    // A taken command makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command taken but busy not raised");

    // Busy drops exactly with the final beat
    a_fall_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && result.last)
        else $error("busy dropped without a final beat");

    // Non-final beats only come while still busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
        else $error("non-final beat while idle");

    // Element beats always report success
    a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.element_valid |-> result.status == STATUS_OK)
        else $error("element beat with error status");

    // Beats without an element carry a zero value
    a_no_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.element_valid |-> result.element_value == '0)
        else $error("nonzero value on a beat without element");

endmodule

bind positional_list_engine_core plist_checker u_plist_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
